/* rtl/assert_macros.svh */
// assertion macros used by literal_classifier_converter.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define LCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next clock edge outside reset
`define LCC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

/* rtl/lcc_pkg.sv */
// types, constants and character codes for the literal classifier
package lcc_pkg;

  localparam int VALUE_BITS = 31;
  localparam int ACC_W      = VALUE_BITS + 4;

  localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

  typedef enum logic [2:0] {
    CLASS_NONE    = 3'd0,
    CLASS_DECIMAL = 3'd1,
    CLASS_HEX     = 3'd2,
    CLASS_BINARY  = 3'd3,
    CLASS_FLOAT   = 3'd4,
    CLASS_STRING  = 3'd5,
    CLASS_ARRAY   = 3'd6
  } class_t;

  typedef struct packed {
    class_t                  literal_class;
    logic [VALUE_BITS-1:0]   int_value;
    logic                    overflow;
  } result_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_POINT  = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  localparam logic [3:0] HEX_ALPHA_OFS = 4'd10;

endpackage

/* rtl/literal_classifier_converter.sv */
// Literal classifier and converter: takes one literal as a stream of 8-bit
// words, one word per cycle while in_stall is low, with in_is_last marking
// the final word. Space, tab and newline are skipped. On the final word one
// result word comes out with the class (none, decimal, 0x hex, 0b binary,
// float, quoted string, braced array) and, for the integer classes, the
// value saturated at 2^31-1 with out_overflow set when it saturated. The
// per-word accumulator and flag updates sit between the state registers
// and a two-entry result queue, so a new word is taken every cycle while
// that queue has room, and the result of a literal is registered into that
// queue. No clearing pass after reset.
module literal_classifier_converter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_char_code,
  input  logic                           in_is_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_literal_class,
  output logic [lcc_pkg::VALUE_BITS-1:0] out_int_value,
  output logic                           out_overflow
);

  logic [1:0]                     kept_cnt_r, kept_cnt_nxt;
  logic [7:0]                     first_r, first_nxt;
  logic [7:0]                     second_r, second_nxt;
  logic [7:0]                     latest_r, latest_nxt;
  logic                           all_dec_r, all_dec_nxt;
  logic                           hex_ok_r, hex_ok_nxt;
  logic                           bin_ok_r, bin_ok_nxt;
  logic                           pre_ok_r, pre_ok_nxt;
  logic                           post_ok_r, post_ok_nxt;
  logic [1:0]                     pts_r, pts_nxt;
  logic [lcc_pkg::VALUE_BITS-1:0] dec_acc_r, dec_acc_nxt;
  logic [lcc_pkg::VALUE_BITS-1:0] hex_acc_r, hex_acc_nxt;
  logic [lcc_pkg::VALUE_BITS-1:0] bin_acc_r, bin_acc_nxt;
  logic                           dec_ovf_r, dec_ovf_nxt;
  logic                           hex_ovf_r, hex_ovf_nxt;
  logic                           bin_ovf_r, bin_ovf_nxt;

  logic [7:0]                 c;
  logic                       kept;
  logic                       is_digit;
  logic                       is_hex;
  logic                       is_bin;
  logic [3:0]                 hex_digit;
  logic [lcc_pkg::ACC_W-1:0]  dec_ext, hex_ext, bin_ext;
  logic [lcc_pkg::ACC_W-1:0]  dec_wide, hex_wide, bin_wide;
  logic                       dec_sat, hex_sat, bin_sat;
  logic                       accept;
  logic                       push;
  logic                       q_full;
  lcc_pkg::result_t           res;
  lcc_pkg::result_t           q_data;

  assign c        = in_char_code;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && in_is_last;
  assign in_stall = q_full;

  always_comb begin
    kept     = !(c inside {lcc_pkg::CH_SPACE, lcc_pkg::CH_TAB, lcc_pkg::CH_NL});
    is_digit = c inside {[lcc_pkg::CH_ZERO:lcc_pkg::CH_NINE]};
    is_hex   = is_digit || (c inside {[lcc_pkg::CH_LOW_A:lcc_pkg::CH_LOW_F]});
    is_bin   = c inside {lcc_pkg::CH_ZERO, lcc_pkg::CH_ONE};
    if (is_digit) begin
      hex_digit = 4'(c - lcc_pkg::CH_ZERO);
    end else begin
      hex_digit = 4'(c - lcc_pkg::CH_LOW_A) + lcc_pkg::HEX_ALPHA_OFS;
    end
  end

  // value * base + digit, compared against the saturation limit
  always_comb begin
    dec_ext  = lcc_pkg::ACC_W'(dec_acc_r);
    hex_ext  = lcc_pkg::ACC_W'(hex_acc_r);
    bin_ext  = lcc_pkg::ACC_W'(bin_acc_r);
    dec_wide = (dec_ext << 3) + (dec_ext << 1) + lcc_pkg::ACC_W'(4'(c - lcc_pkg::CH_ZERO));
    hex_wide = (hex_ext << 4) + lcc_pkg::ACC_W'(hex_digit);
    bin_wide = (bin_ext << 1) + lcc_pkg::ACC_W'(c[0]);
    dec_sat  = dec_wide > lcc_pkg::ACC_W'(lcc_pkg::VMAX);
    hex_sat  = hex_wide > lcc_pkg::ACC_W'(lcc_pkg::VMAX);
    bin_sat  = bin_wide > lcc_pkg::ACC_W'(lcc_pkg::VMAX);
  end

  always_comb begin
    kept_cnt_nxt = kept_cnt_r;
    first_nxt    = first_r;
    second_nxt   = second_r;
    latest_nxt   = latest_r;
    all_dec_nxt  = all_dec_r;
    hex_ok_nxt   = hex_ok_r;
    bin_ok_nxt   = bin_ok_r;
    pre_ok_nxt   = pre_ok_r;
    post_ok_nxt  = post_ok_r;
    pts_nxt      = pts_r;
    dec_acc_nxt  = dec_acc_r;
    hex_acc_nxt  = hex_acc_r;
    bin_acc_nxt  = bin_acc_r;
    dec_ovf_nxt  = dec_ovf_r;
    hex_ovf_nxt  = hex_ovf_r;
    bin_ovf_nxt  = bin_ovf_r;
    if (kept) begin
      if (is_digit) begin
        if (dec_sat) begin
          dec_acc_nxt = lcc_pkg::VMAX;
          dec_ovf_nxt = 1'b1;
        end else begin
          dec_acc_nxt = dec_wide[lcc_pkg::VALUE_BITS-1:0];
        end
      end else begin
        all_dec_nxt = 1'b0;
      end
      // digits after the two-character prefix
      if (kept_cnt_r[1]) begin
        if (is_hex) begin
          if (hex_sat) begin
            hex_acc_nxt = lcc_pkg::VMAX;
            hex_ovf_nxt = 1'b1;
          end else begin
            hex_acc_nxt = hex_wide[lcc_pkg::VALUE_BITS-1:0];
          end
        end else begin
          hex_ok_nxt = 1'b0;
        end
        if (is_bin) begin
          if (bin_sat) begin
            bin_acc_nxt = lcc_pkg::VMAX;
            bin_ovf_nxt = 1'b1;
          end else begin
            bin_acc_nxt = bin_wide[lcc_pkg::VALUE_BITS-1:0];
          end
        end else begin
          bin_ok_nxt = 1'b0;
        end
      end
      if (c == lcc_pkg::CH_POINT) begin
        if (pts_r != 2'd2) begin
          pts_nxt = pts_r + 2'd1;
        end
      end else if (!is_digit) begin
        if (pts_r == 2'd0) begin
          pre_ok_nxt = 1'b0;
        end else begin
          post_ok_nxt = 1'b0;
        end
      end
      if (kept_cnt_r == 2'd0) begin
        first_nxt = c;
      end
      if (kept_cnt_r == 2'd1) begin
        second_nxt = c;
      end
      latest_nxt = c;
      if (kept_cnt_r != 2'd3) begin
        kept_cnt_nxt = kept_cnt_r + 2'd1;
      end
    end
  end

  always_comb begin
    res.literal_class = lcc_pkg::CLASS_NONE;
    res.int_value     = '0;
    res.overflow      = 1'b0;
    if ((kept_cnt_nxt != 2'd0) && all_dec_nxt) begin
      res.literal_class = lcc_pkg::CLASS_DECIMAL;
      res.int_value     = dec_acc_nxt;
      res.overflow      = dec_ovf_nxt;
    end else if ((kept_cnt_nxt == 2'd3) && (first_nxt == lcc_pkg::CH_ZERO) &&
                 (second_nxt == lcc_pkg::CH_LOW_X) && hex_ok_nxt) begin
      res.literal_class = lcc_pkg::CLASS_HEX;
      res.int_value     = hex_acc_nxt;
      res.overflow      = hex_ovf_nxt;
    end else if ((kept_cnt_nxt == 2'd3) && (first_nxt == lcc_pkg::CH_ZERO) &&
                 (second_nxt == lcc_pkg::CH_LOW_B) && bin_ok_nxt) begin
      res.literal_class = lcc_pkg::CLASS_BINARY;
      res.int_value     = bin_acc_nxt;
      res.overflow      = bin_ovf_nxt;
    end else if ((pts_nxt == 2'd1) && pre_ok_nxt && post_ok_nxt &&
                 (first_nxt != lcc_pkg::CH_POINT) && (latest_nxt != lcc_pkg::CH_POINT)) begin
      res.literal_class = lcc_pkg::CLASS_FLOAT;
    end else if (kept_cnt_nxt[1] && (first_nxt == lcc_pkg::CH_QUOTE) &&
                 (latest_nxt == lcc_pkg::CH_QUOTE)) begin
      res.literal_class = lcc_pkg::CLASS_STRING;
    end else if (kept_cnt_nxt[1] && (first_nxt == lcc_pkg::CH_LBRACE) &&
                 (latest_nxt == lcc_pkg::CH_RBRACE)) begin
      res.literal_class = lcc_pkg::CLASS_ARRAY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      kept_cnt_r <= 2'd0;
      first_r    <= 8'd0;
      second_r   <= 8'd0;
      latest_r   <= 8'd0;
      all_dec_r  <= 1'b1;
      hex_ok_r   <= 1'b1;
      bin_ok_r   <= 1'b1;
      pre_ok_r   <= 1'b1;
      post_ok_r  <= 1'b1;
      pts_r      <= 2'd0;
      dec_acc_r  <= '0;
      hex_acc_r  <= '0;
      bin_acc_r  <= '0;
      dec_ovf_r  <= 1'b0;
      hex_ovf_r  <= 1'b0;
      bin_ovf_r  <= 1'b0;
    end else if (accept) begin
      kept_cnt_r <= kept_cnt_nxt;
      first_r    <= first_nxt;
      second_r   <= second_nxt;
      latest_r   <= latest_nxt;
      all_dec_r  <= all_dec_nxt;
      hex_ok_r   <= hex_ok_nxt;
      bin_ok_r   <= bin_ok_nxt;
      pre_ok_r   <= pre_ok_nxt;
      post_ok_r  <= post_ok_nxt;
      pts_r      <= pts_nxt;
      dec_acc_r  <= dec_acc_nxt;
      hex_acc_r  <= hex_acc_nxt;
      bin_acc_r  <= bin_acc_nxt;
      dec_ovf_r  <= dec_ovf_nxt;
      hex_ovf_r  <= hex_ovf_nxt;
      bin_ovf_r  <= bin_ovf_nxt;
    end
  end

  lcc_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (q_data),
    .full      (q_full)
  );

  assign out_literal_class = q_data.literal_class;
  assign out_int_value     = q_data.int_value;
  assign out_overflow      = q_data.overflow;

`include "assert_macros.svh"

  `LCC_ASSERT(a_ovf_int_only, !out_valid || !out_overflow || (out_literal_class == lcc_pkg::CLASS_DECIMAL) || (out_literal_class == lcc_pkg::CLASS_HEX) || (out_literal_class == lcc_pkg::CLASS_BINARY), "overflow on a non-integer class")
  `LCC_ASSERT(a_value_int_only, !out_valid || (out_int_value == '0) || (out_literal_class == lcc_pkg::CLASS_DECIMAL) || (out_literal_class == lcc_pkg::CLASS_HEX) || (out_literal_class == lcc_pkg::CLASS_BINARY), "value on a non-integer class")
  `LCC_ASSERT(a_stall_needs_result, !in_stall || out_valid, "input stalled with no result pending")
  `LCC_ASSERT_NEXT(a_restart_after_last, push, (kept_cnt_r == 2'd0) && (pts_r == 2'd0) && all_dec_r, "scan state not cleared after last word")

endmodule

/* rtl/lcc_out_queue.sv */
// two-entry result queue between the scanner and the output channel
module lcc_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lcc_pkg::result_t  push_data,
  input  logic              out_stall,
  output logic              out_valid,
  output lcc_pkg::result_t  out_data,
  output logic              full
);

  lcc_pkg::result_t head_r, head_nxt;
  lcc_pkg::result_t tail_r, tail_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign out_data  = head_r;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          head_nxt = push_data;
          cnt_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_data;
        end else if (push) begin
          tail_nxt = push_data;
          cnt_nxt  = 2'd2;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt = tail_r;
          cnt_nxt  = 2'd1;
        end
      end
      default: begin
        cnt_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

/* tb/literal_classifier_converter_test.sv */
// self-checking testbench for the literal classifier with its own prediction of every result
module literal_classifier_converter_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] VAL_MAX    = 64'(lcc_pkg::VMAX);
  localparam int          WORD_COUNT = 1700;
  localparam int          IDLE_LIMIT = 1000;
  localparam int          DRAIN_WAIT = 24;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } char_word_t;

  typedef enum {
    SHAPE_DEC, SHAPE_HEX, SHAPE_BIN, SHAPE_FLOAT, SHAPE_STR, SHAPE_ARR, SHAPE_NOISE
  } shape_kind_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     in_char_code = 8'd0;
  logic                           in_is_last = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [2:0]                     out_literal_class;
  logic [lcc_pkg::VALUE_BITS-1:0] out_int_value;
  logic                           out_overflow;

  literal_classifier_converter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_code      (in_char_code),
    .in_is_last        (in_is_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_literal_class (out_literal_class),
    .out_int_value     (out_int_value),
    .out_overflow      (out_overflow)
  );

  always #10 clk = ~clk;

  // predicted literal state
  logic [1:0]  kept;
  logic [7:0]  first_kept;
  logic [7:0]  second_kept;
  logic [7:0]  latest_kept;
  logic        all_dec;
  logic        all_hex;
  logic        all_bin;
  logic        pre_ok;
  logic        post_ok;
  logic [1:0]  points;
  logic [63:0] dec_acc;
  logic [63:0] hex_acc;
  logic [63:0] bin_acc;
  logic        dec_sat;
  logic        hex_sat;
  logic        bin_sat;

  lcc_pkg::result_t expected_results[$];
  char_word_t       pending_words[$];
  logic [7:0]       text[$];
  char_word_t       next_word;
  lcc_pkg::result_t want;
  int               word_count = 0;
  int               errors = 0;
  int               in_gap = 0;
  int               out_hold = 0;
  int               draw;
  int               idle_cycles = 0;
  logic             in_calm = 1'b0;
  logic             out_calm = 1'b0;
  logic             timed_out = 1'b0;
  logic             moved;

  task automatic clear_literal();
    kept = 2'd0;
    first_kept = 8'd0;
    second_kept = 8'd0;
    latest_kept = 8'd0;
    all_dec = 1'b1;
    all_hex = 1'b1;
    all_bin = 1'b1;
    pre_ok = 1'b1;
    post_ok = 1'b1;
    points = 2'd0;
    dec_acc = 64'd0;
    hex_acc = 64'd0;
    bin_acc = 64'd0;
    dec_sat = 1'b0;
    hex_sat = 1'b0;
    bin_sat = 1'b0;
  endtask

  task automatic sat_mac(inout logic [63:0] acc, inout logic sat, input logic [63:0] base,
                         input logic [63:0] digit);
    if (acc > (VAL_MAX - digit) / base) begin
      acc = VAL_MAX;
      sat = 1'b1;
    end else begin
      acc = acc * base + digit;
    end
  endtask

  task automatic classify_char(input logic [7:0] c, input logic last);
    logic             is_digit;
    lcc_pkg::result_t r;
    if (c != lcc_pkg::CH_SPACE && c != lcc_pkg::CH_TAB && c != lcc_pkg::CH_NL) begin
      is_digit = (c >= lcc_pkg::CH_ZERO && c <= lcc_pkg::CH_NINE);
      if (is_digit) sat_mac(dec_acc, dec_sat, 64'd10, 64'(c - lcc_pkg::CH_ZERO));
      else all_dec = 1'b0;
      if (kept >= 2'd2) begin
        if (is_digit) sat_mac(hex_acc, hex_sat, 64'd16, 64'(c - lcc_pkg::CH_ZERO));
        else if (c >= lcc_pkg::CH_LOW_A && c <= lcc_pkg::CH_LOW_F)
          sat_mac(hex_acc, hex_sat, 64'd16,
                  64'(c - lcc_pkg::CH_LOW_A) + 64'(lcc_pkg::HEX_ALPHA_OFS));
        else all_hex = 1'b0;
        if (c == lcc_pkg::CH_ZERO || c == lcc_pkg::CH_ONE)
          sat_mac(bin_acc, bin_sat, 64'd2, 64'(c - lcc_pkg::CH_ZERO));
        else all_bin = 1'b0;
      end
      if (c == lcc_pkg::CH_POINT) begin
        if (points < 2'd2) points = points + 2'd1;
      end else if (!is_digit) begin
        if (points == 2'd0) pre_ok = 1'b0;
        else post_ok = 1'b0;
      end
      if (kept == 2'd0) first_kept = c;
      if (kept == 2'd1) second_kept = c;
      latest_kept = c;
      if (kept < 2'd3) kept = kept + 2'd1;
    end
    if (last) begin
      r.literal_class = lcc_pkg::CLASS_NONE;
      r.int_value = '0;
      r.overflow = 1'b0;
      if (kept >= 2'd1 && all_dec) begin
        r.literal_class = lcc_pkg::CLASS_DECIMAL;
        r.int_value = dec_acc[lcc_pkg::VALUE_BITS-1:0];
        r.overflow = dec_sat;
      end else if (kept == 2'd3 && first_kept == lcc_pkg::CH_ZERO &&
                   second_kept == lcc_pkg::CH_LOW_X && all_hex) begin
        r.literal_class = lcc_pkg::CLASS_HEX;
        r.int_value = hex_acc[lcc_pkg::VALUE_BITS-1:0];
        r.overflow = hex_sat;
      end else if (kept == 2'd3 && first_kept == lcc_pkg::CH_ZERO &&
                   second_kept == lcc_pkg::CH_LOW_B && all_bin) begin
        r.literal_class = lcc_pkg::CLASS_BINARY;
        r.int_value = bin_acc[lcc_pkg::VALUE_BITS-1:0];
        r.overflow = bin_sat;
      end else if (points == 2'd1 && pre_ok && post_ok && first_kept != lcc_pkg::CH_POINT &&
                   latest_kept != lcc_pkg::CH_POINT) begin
        r.literal_class = lcc_pkg::CLASS_FLOAT;
      end else if (kept >= 2'd2 && first_kept == lcc_pkg::CH_QUOTE &&
                   latest_kept == lcc_pkg::CH_QUOTE) begin
        r.literal_class = lcc_pkg::CLASS_STRING;
      end else if (kept >= 2'd2 && first_kept == lcc_pkg::CH_LBRACE &&
                   latest_kept == lcc_pkg::CH_RBRACE) begin
        r.literal_class = lcc_pkg::CLASS_ARRAY;
      end
      expected_results.insert(expected_results.size(), r);
      clear_literal();
    end
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 2))
      0: pick_space = lcc_pkg::CH_SPACE;
      1: pick_space = lcc_pkg::CH_TAB;
      default: pick_space = lcc_pkg::CH_NL;
    endcase
  endfunction

  task automatic add_char(input logic [7:0] ch);
    text.insert(text.size(), ch);
  endtask

  task automatic push_word(input logic [7:0] c, input logic last);
    char_word_t w;
    w.code = c;
    w.last = last;
    pending_words.insert(pending_words.size(), w);
    word_count++;
  endtask

  // turn the text buffer into words, optionally sprinkling whitespace
  task automatic emit_text(input bit sprinkle);
    bit trail;
    trail = sprinkle && ($urandom_range(0, 7) == 0);
    if (text.size() == 0 && !trail) add_char(pick_space());
    for (int i = 0; i < text.size(); i++) begin
      if (sprinkle && $urandom_range(0, 9) == 0) push_word(pick_space(), 1'b0);
      push_word(text[i], !trail && (i == text.size() - 1));
    end
    if (trail) push_word(pick_space(), 1'b1);
    text.delete();
  endtask

  task automatic add_string(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    emit_text(1'b0);
  endtask

  task automatic add_digits(input int lo, input int hi, input int radix);
    int n;
    int v;
    n = $urandom_range(lo, hi);
    repeat (n) begin
      v = $urandom_range(0, radix - 1);
      if (v < 10) add_char(lcc_pkg::CH_ZERO + 8'(v));
      else add_char(lcc_pkg::CH_LOW_A + 8'(v) - 8'(lcc_pkg::HEX_ALPHA_OFS));
    end
  endtask

  task automatic add_noise(input int hi);
    repeat ($urandom_range(0, hi)) add_char(8'($urandom_range(0, 255)));
  endtask

  task automatic add_random_literal();
    shape_kind_t kind;
    int          pos;
    bit          deep;
    kind = shape_kind_t'($urandom_range(0, 6));
    deep = ($urandom_range(0, 3) == 0);
    case (kind)
      SHAPE_DEC: begin
        if (deep) add_digits(8, 12, 10);
        else add_digits(1, 4, 10);
      end
      SHAPE_HEX: begin
        add_char(lcc_pkg::CH_ZERO);
        add_char(lcc_pkg::CH_LOW_X);
        if (deep) add_digits(7, 9, 16);
        else add_digits(1, 4, 16);
      end
      SHAPE_BIN: begin
        add_char(lcc_pkg::CH_ZERO);
        add_char(lcc_pkg::CH_LOW_B);
        if (deep) add_digits(28, 34, 2);
        else add_digits(1, 8, 2);
      end
      SHAPE_FLOAT: begin
        add_digits(1, 4, 10);
        add_char(lcc_pkg::CH_POINT);
        add_digits(1, 4, 10);
      end
      SHAPE_STR: begin
        add_char(lcc_pkg::CH_QUOTE);
        add_noise(5);
        add_char(lcc_pkg::CH_QUOTE);
      end
      SHAPE_ARR: begin
        add_char(lcc_pkg::CH_LBRACE);
        add_noise(5);
        add_char(lcc_pkg::CH_RBRACE);
      end
      default: add_noise(6);
    endcase
    // broken variants of the generated literals, noise included
    if ($urandom_range(0, 4) == 0 && text.size() != 0) begin
      pos = $urandom_range(0, text.size() - 1);
      case ($urandom_range(0, 2))
        0: text[pos] = 8'($urandom_range(0, 255));
        1: void'(text.pop_back());
        default: text.insert(pos, lcc_pkg::CH_POINT);
      endcase
    end
    emit_text(1'b1);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_words.size() != 0) begin
        next_word = pending_words.pop_front();
        in_valid <= 1'b1;
        in_char_code <= next_word.code;
        in_is_last <= next_word.last;
        if ($urandom_range(0, 59) == 0) in_calm <= !in_calm;
        in_gap <= in_calm ? 0 : $urandom_range(0, 16);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor, result check and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      moved = (in_valid && !in_stall) || (out_valid && !out_stall);
      if (in_valid && !in_stall) classify_char(in_char_code, in_is_last);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word: class %0d value %0d overflow %0d", $time,
                   out_literal_class, out_int_value, out_overflow);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_literal_class !== want.literal_class) begin
            $display("%0t: class expected %0d actual %0d", $time, want.literal_class,
                     out_literal_class);
            errors++;
          end
          if (out_int_value !== want.int_value) begin
            $display("%0t: value expected %0d actual %0d", $time, want.int_value,
                     out_int_value);
            errors++;
          end
          if (out_overflow !== want.overflow) begin
            $display("%0t: overflow expected %0d actual %0d", $time, want.overflow,
                     out_overflow);
            errors++;
          end
        end
        if ($urandom_range(0, 39) == 0) out_calm <= !out_calm;
        draw = out_calm ? 0 : $urandom_range(0, 16);
        out_hold <= draw;
        out_stall <= (draw != 0);
      end else if (out_hold != 0) begin
        out_hold <= out_hold - 1;
        out_stall <= (out_hold > 1);
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) timed_out <= 1'b1;
    end
  end

  initial begin
    clear_literal();
    add_string("0");
    add_string("2147483647");
    add_string("2147483648");
    add_string("99999999999");
    add_string("0x7fffffff");
    add_string("0x80000000");
    add_string("0xAB");
    add_string("0x1g");
    add_string("0x");
    add_string("0b");
    add_string("0b101");
    add_string("0b11111111111111111111111111111111");
    add_string("1.5");
    add_string(".5");
    add_string("5.");
    add_string("1.2.3");
    add_string("\"\"");
    add_string("\"a");
    add_string("{1,2}");
    add_string("{");
    add_string(" \t\n");
    add_string(" 4 2\n");
    add_string("abc");
    add_char(8'hff);
    emit_text(1'b0);
    add_char(8'h80);
    add_char(lcc_pkg::CH_ZERO);
    emit_text(1'b0);
    while (word_count < WORD_COUNT) add_random_literal();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (!(pending_words.size() == 0 && !in_valid && expected_results.size() == 0) &&
           !timed_out)
      @(posedge clk);
    if (!timed_out) repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && !timed_out && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* literal_classifier_converter.f */
+incdir+rtl
rtl/lcc_pkg.sv
rtl/lcc_out_queue.sv
rtl/literal_classifier_converter.sv
tb/literal_classifier_converter_test.sv
